// ===== rtl/gmf_pkg.sv =====
`timescale 1ns / 1ps
package gmf_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CFG_GAUSS_SCALE = 2'd0,
      CFG_WAVE_NUMBER = 2'd1,
      CFG_AMPLITUDE   = 2'd2
   } cfg_index_type;

   // Fixed-point constants of the mode function.
   localparam logic [31:0] LN2_Q32      = 32'hB172_17F8;
   localparam logic [34:0] PI_Q32       = 35'h3_243F_6A89;
   localparam logic [34:0] HALF_PI_Q32  = 35'h1_921F_B544;
   localparam logic [42:0] TWO_PI_Q40   = 43'h648_7ED5_110B;
   localparam logic [63:0] EXP_LIMIT_Q24 = 64'd24 << 24;

   // The phase product is below 2^80 for positions of up to 48 bits, so 38
   // restoring steps leave the remainder below 2*pi.
   localparam int unsigned MOD_W     = 81;
   localparam int unsigned MOD_STEPS = 38;

   // Octave count of the exponential stays below 64.
   localparam int unsigned QDIV_W     = 38;
   localparam int unsigned QDIV_STEPS = 6;

   localparam int unsigned EXP_TERMS   = 12;
   localparam int unsigned SIN_TERMS   = 6;
   localparam int unsigned CELL_STAGES = 3;

   typedef struct packed {
      logic neg;
      logic last;
   } tag_type;

   typedef struct packed {
      logic [31:0] field_y;
      logic        saturated;
      logic        last_result;
   } result_type;

   function automatic int unsigned sin_div(input int unsigned idx);
      int unsigned d;
      case (idx)
         0: d = 156;
         1: d = 110;
         2: d = 72;
         3: d = 42;
         4: d = 20;
         default: d = 6;
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/gmf_if.sv =====
`timescale 1ns / 1ps
interface gmf_req_if #(
   parameter int unsigned POS_W = 32
);
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] x_pos;
   logic signed [POS_W-1:0] y_pos;
   logic signed [POS_W-1:0] z_pos;
   logic                    last_point;

   modport source (output valid, x_pos, y_pos, z_pos, last_point, input ready);
   modport sink   (input valid, x_pos, y_pos, z_pos, last_point, output ready);
endinterface

interface gmf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] field_y;
   logic               saturated;
   logic               last_result;

   modport source (output valid, field_y, saturated, last_result, input ready);
   modport sink   (input valid, field_y, saturated, last_result, output ready);
endinterface

// ===== rtl/gaussian_mode_field_eval.sv =====
`timescale 1ns / 1ps
// Evaluates amplitude * exp(-gauss_scale*(y^2+z^2)) * sin(wave_number*x) for one point a
// cycle; a request enters every clock unless both output slots are full and unread. The
// phase is reduced modulo 2*pi by the 38-step restoring reduction, followed by the six three-stage
// cells of the sine series, while the exponential's twelve cells run alongside. Two
// finished results can wait at the output; the pipeline holds only while both are unread.
module gaussian_mode_field_eval #(
   parameter int unsigned POSITION_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   gmf_req_if.sink                           req_ch,
   gmf_rsp_if.source                         rsp_ch,
   input  logic                              csr_write,
   input  logic [gmf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gmf_pkg::CSR_DATA_W-1:0]    csr_data
);
   import gmf_pkg::*;

   localparam int unsigned P_W     = POSITION_BITS;
   localparam int unsigned EXP_LAT = 2 + QDIV_STEPS + EXP_TERMS * CELL_STAGES + 2;
   localparam int unsigned SIN_LAT = MOD_STEPS + 2 + SIN_TERMS * CELL_STAGES + 1;
   localparam int unsigned DLY     = SIN_LAT - EXP_LAT;
   localparam int unsigned TAG_W   = $bits(tag_type);
   localparam int unsigned SIN_SIDE_W = 31 + TAG_W;

   logic        advance;
   logic [31:0] gauss_scale_ff, wave_number_ff, amplitude_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gauss_scale_ff <= '0;
         wave_number_ff <= '0;
         amplitude_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CFG_GAUSS_SCALE: gauss_scale_ff <= csr_data;
            CFG_WAVE_NUMBER: wave_number_ff <= csr_data;
            CFG_AMPLITUDE:   amplitude_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_ch.ready = advance;

   // Input stage: magnitudes, transverse ones clipped to 32 bits.
   logic [P_W-1:0] x_raw, y_raw, z_raw;
   logic [P_W-1:0] x_mag, y_mag, z_mag;
   logic [31:0]    y_clip, z_clip;

   assign x_raw = req_ch.x_pos;
   assign y_raw = req_ch.y_pos;
   assign z_raw = req_ch.z_pos;
   assign x_mag = x_raw[P_W-1] ? ~x_raw + 1'b1 : x_raw;
   assign y_mag = y_raw[P_W-1] ? ~y_raw + 1'b1 : y_raw;
   assign z_mag = z_raw[P_W-1] ? ~z_raw + 1'b1 : z_raw;

   generate
      if (P_W > 32) begin : g_clip
         assign y_clip = (|y_mag[P_W-1:32]) ? '1 : y_mag[31:0];
         assign z_clip = (|z_mag[P_W-1:32]) ? '1 : z_mag[31:0];
      end else begin : g_noclip
         assign y_clip = 32'(y_mag);
         assign z_clip = 32'(z_mag);
      end
   endgenerate

   logic           s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [P_W-1:0] s1_ax_ff;
   logic [31:0]    s1_ay_ff, s1_az_ff;
   tag_type        s1_tag_ff, s2_tag_ff, s3_tag_ff;
   logic [63:0]    s2_sy_ff, s2_sz_ff, s2_p0_ff, s2_p1_ff;
   logic [63:0]    s3_sum_ff;
   logic [MOD_W-1:0] s3_phase_ff;
   logic [63:0]    ax_wide;
   logic [64:0]    sum_wide;

   assign ax_wide  = 64'(s1_ax_ff);
   assign sum_wide = {1'b0, s2_sy_ff} + {1'b0, s2_sz_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_ch.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ax_ff       <= x_mag;
         s1_ay_ff       <= y_clip;
         s1_az_ff       <= z_clip;
         s1_tag_ff.neg  <= x_raw[P_W-1];
         s1_tag_ff.last <= req_ch.last_point;
         s2_sy_ff       <= s1_ay_ff * s1_ay_ff;
         s2_sz_ff       <= s1_az_ff * s1_az_ff;
         s2_p0_ff       <= ax_wide[31:0] * wave_number_ff;
         s2_p1_ff       <= ax_wide[63:32] * wave_number_ff;
         s2_tag_ff      <= s1_tag_ff;
         s3_sum_ff      <= sum_wide[64] ? '1 : sum_wide[63:0];
         s3_phase_ff    <= MOD_W'({s2_p1_ff, 32'd0}) + MOD_W'(s2_p0_ff);
         s3_tag_ff      <= s2_tag_ff;
      end
   end

   // Gaussian branch: argument, then octave split of the exponential.
   logic [63:0] s4_lo_ff, s4_hi_ff;
   logic [64:0] e_wide;
   logic        s5_zero_ff;
   logic [QDIV_W-1:0] s5_big_ff;

   assign e_wide = {1'b0, s4_hi_ff} + 65'(s4_lo_ff[63:32]);

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_lo_ff   <= s3_sum_ff[31:0] * gauss_scale_ff;
         s4_hi_ff   <= s3_sum_ff[63:32] * gauss_scale_ff;
         s5_zero_ff <= e_wide[64] || (e_wide[63:0] >= EXP_LIMIT_Q24);
         s5_big_ff  <= QDIV_W'({e_wide[28:0], 8'd0});
      end
   end

   logic [QDIV_W-1:0]     qd_rem  [QDIV_STEPS+1];
   logic [QDIV_STEPS-1:0] qd_q    [QDIV_STEPS+1];
   logic                  qd_zero [QDIV_STEPS+1];

   assign qd_rem[0]  = s5_big_ff;
   assign qd_q[0]    = '0;
   assign qd_zero[0] = s5_zero_ff;

   generate
      for (genvar k = 0; k < QDIV_STEPS; k++) begin : g_qdiv
         localparam logic [QDIV_W-1:0] SUB = QDIV_W'(LN2_Q32) << (QDIV_STEPS - 1 - k);
         gmf_csub_cell #(
            .W(QDIV_W), .SIDE_W(1), .Q_W(QDIV_STEPS), .SUB(SUB)
         ) u_step (
            .clock(clock), .reset(reset), .advance(advance),
            .in_valid(1'b1), .in_rem(qd_rem[k]), .in_q(qd_q[k]), .in_side(qd_zero[k]),
            .out_valid(), .out_rem(qd_rem[k+1]), .out_q(qd_q[k+1]),
            .out_side(qd_zero[k+1])
         );
      end
   endgenerate

   logic [31:0] ex_op   [EXP_TERMS+1];
   logic [32:0] ex_t    [EXP_TERMS+1];
   logic [QDIV_STEPS:0] ex_side [EXP_TERMS+1];

   assign ex_op[0]   = qd_rem[QDIV_STEPS][31:0];
   assign ex_t[0]    = 33'h1_0000_0000;
   assign ex_side[0] = {qd_zero[QDIV_STEPS], qd_q[QDIV_STEPS]};

   generate
      for (genvar i = 0; i < EXP_TERMS; i++) begin : g_exp
         gmf_series_cell #(
            .OP_W(32), .FRAC(32), .DIV(EXP_TERMS - i), .SIDE_W(QDIV_STEPS + 1)
         ) u_cell (
            .clock(clock), .reset(reset), .advance(advance),
            .in_valid(1'b1), .in_op(ex_op[i]), .in_t(ex_t[i]), .in_side(ex_side[i]),
            .out_valid(), .out_op(ex_op[i+1]), .out_t(ex_t[i+1]),
            .out_side(ex_side[i+1])
         );
      end
   endgenerate

   logic [32:0] g_ff;
   logic [64:0] amp_prod;
   logic [39:0] m_ff;
   logic [39:0] m_dly_ff [DLY];

   assign amp_prod = amplitude_ff * g_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         g_ff <= ex_side[EXP_TERMS][QDIV_STEPS] ? '0
                 : ex_t[EXP_TERMS] >> ex_side[EXP_TERMS][QDIV_STEPS-1:0];
         m_ff <= amp_prod[63:24];
         m_dly_ff[0] <= m_ff;
         for (int j = 1; j < DLY; j++) begin
            m_dly_ff[j] <= m_dly_ff[j-1];
         end
      end
   end

   // Sine branch: phase reduced modulo 2*pi one quotient bit per cell.
   logic [MOD_W-1:0] md_rem   [MOD_STEPS+1];
   logic [TAG_W-1:0] md_side  [MOD_STEPS+1];
   logic             md_valid [MOD_STEPS+1];

   assign md_rem[0]   = s3_phase_ff;
   assign md_side[0]  = s3_tag_ff;
   assign md_valid[0] = s3_valid_ff;

   generate
      for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
         localparam logic [MOD_W-1:0] SUB = MOD_W'(TWO_PI_Q40) << (MOD_STEPS - 1 - j);
         gmf_csub_cell #(
            .W(MOD_W), .SIDE_W(TAG_W), .Q_W(1), .SUB(SUB)
         ) u_step (
            .clock(clock), .reset(reset), .advance(advance),
            .in_valid(md_valid[j]), .in_rem(md_rem[j]), .in_q(1'b0), .in_side(md_side[j]),
            .out_valid(md_valid[j+1]), .out_rem(md_rem[j+1]), .out_q(),
            .out_side(md_side[j+1])
         );
      end
   endgenerate

   // Fold the angle into the first quadrant; the half turn flips the sign.
   logic [34:0] fold_a0, fold_a1, fold_a2;
   logic        fold_flip;
   tag_type     fold_tag;

   always_comb begin
      fold_a0      = md_rem[MOD_STEPS][42:8];
      fold_flip    = fold_a0 >= PI_Q32;
      fold_a1      = fold_flip ? fold_a0 - PI_Q32 : fold_a0;
      fold_a2      = (fold_a1 > HALF_PI_Q32) ? PI_Q32 - fold_a1 : fold_a1;
      fold_tag     = md_side[MOD_STEPS];
      fold_tag.neg = fold_tag.neg ^ fold_flip;
   end

   logic        s42_valid_ff, s43_valid_ff;
   logic [30:0] s42_u_ff, s43_u_ff;
   tag_type     s42_tag_ff, s43_tag_ff;
   logic [31:0] s43_u2_ff;
   logic [61:0] u_sq;

   assign u_sq = s42_u_ff * s42_u_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s42_valid_ff <= 1'b0;
         s43_valid_ff <= 1'b0;
      end else if (advance) begin
         s42_valid_ff <= md_valid[MOD_STEPS];
         s43_valid_ff <= s42_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s42_u_ff   <= fold_a2[32:2];
         s42_tag_ff <= fold_tag;
         s43_u_ff   <= s42_u_ff;
         s43_tag_ff <= s42_tag_ff;
         s43_u2_ff  <= u_sq[61:30];
      end
   end

   logic [31:0]           sn_op    [SIN_TERMS+1];
   logic [30:0]           sn_t     [SIN_TERMS+1];
   logic [SIN_SIDE_W-1:0] sn_side  [SIN_TERMS+1];
   logic                  sn_valid [SIN_TERMS+1];

   assign sn_op[0]    = s43_u2_ff;
   assign sn_t[0]     = 31'h4000_0000;
   assign sn_side[0]  = {s43_u_ff, s43_tag_ff};
   assign sn_valid[0] = s43_valid_ff;

   generate
      for (genvar i = 0; i < SIN_TERMS; i++) begin : g_sin
         gmf_series_cell #(
            .OP_W(32), .FRAC(30), .DIV(sin_div(i)), .SIDE_W(SIN_SIDE_W)
         ) u_cell (
            .clock(clock), .reset(reset), .advance(advance),
            .in_valid(sn_valid[i]), .in_op(sn_op[i]), .in_t(sn_t[i]), .in_side(sn_side[i]),
            .out_valid(sn_valid[i+1]), .out_op(sn_op[i+1]), .out_t(sn_t[i+1]),
            .out_side(sn_side[i+1])
         );
      end
   endgenerate

   // Combine: sine magnitude, amplitude-scaled Gaussian, rounding and clipping.
   logic [30:0] sn_u;
   tag_type     sn_tag;
   logic [61:0] sine_prod;
   logic        s62_valid_ff, s63_valid_ff;
   logic [30:0] s62_s_ff;
   tag_type     s62_tag_ff, s63_tag_ff;
   logic [62:0] s63_prod_ff;

   assign sn_u      = sn_side[SIN_TERMS][SIN_SIDE_W-1:TAG_W];
   assign sn_tag    = sn_side[SIN_TERMS][TAG_W-1:0];
   assign sine_prod = sn_u * sn_t[SIN_TERMS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s62_valid_ff <= 1'b0;
         s63_valid_ff <= 1'b0;
      end else if (advance) begin
         s62_valid_ff <= sn_valid[SIN_TERMS];
         s63_valid_ff <= s62_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s62_s_ff    <= sine_prod[60:30];
         s62_tag_ff  <= sn_tag;
         s63_prod_ff <= m_dly_ff[DLY-1] * s62_s_ff[30:8];
         s63_tag_ff  <= s62_tag_ff;
      end
   end

   logic [63:0] rounded;
   logic [33:0] mag;
   result_type  result;

   always_comb begin
      rounded            = 64'(s63_prod_ff) + (64'd1 << 29);
      mag                = rounded[63:30];
      result.last_result = s63_tag_ff.last;
      result.saturated   = 1'b0;
      if (mag == '0) begin
         result.field_y = '0;
      end else if (!s63_tag_ff.neg) begin
         if (mag > 34'h0_7FFF_FFFF) begin
            result.field_y   = 32'h7FFF_FFFF;
            result.saturated = 1'b1;
         end else begin
            result.field_y = mag[31:0];
         end
      end else begin
         if (mag > 34'h0_8000_0000) begin
            result.field_y   = 32'h8000_0000;
            result.saturated = 1'b1;
         end else begin
            result.field_y = ~mag[31:0] + 1'b1;
         end
      end
   end

   gmf_out_buffer u_out (
      .clock(clock),
      .reset(reset),
      .push(advance && s63_valid_ff),
      .push_data(result),
      .advance(advance),
      .rsp_ch(rsp_ch)
   );
endmodule

// ===== rtl/gmf_csub_cell.sv =====
`timescale 1ns / 1ps
module gmf_csub_cell #(
   parameter int unsigned     W      = 81,
   parameter int unsigned     SIDE_W = 1,
   parameter int unsigned     Q_W    = 1,
   parameter logic [W-1:0]    SUB    = '0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [W-1:0]      in_rem,
   input  logic [Q_W-1:0]    in_q,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [W-1:0]      out_rem,
   output logic [Q_W-1:0]    out_q,
   output logic [SIDE_W-1:0] out_side
);
   logic              take;
   logic [W-1:0]      rem_in;
   logic [Q_W-1:0]    q_in;
   logic              valid_ff;
   logic [W-1:0]      rem_ff;
   logic [Q_W-1:0]    q_ff;
   logic [SIDE_W-1:0] side_ff;

   assign take   = in_rem >= SUB;
   assign rem_in = take ? in_rem - SUB : in_rem;

   generate
      if (Q_W > 1) begin : g_shift
         assign q_in = {in_q[Q_W-2:0], take};
      end else begin : g_bit
         assign q_in = take;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         q_ff    <= q_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_q     = q_ff;
   assign out_side  = side_ff;
endmodule

// ===== rtl/gmf_series_cell.sv =====
`timescale 1ns / 1ps
module gmf_series_cell #(
   parameter int unsigned OP_W   = 32,
   parameter int unsigned FRAC   = 32,
   parameter int unsigned DIV    = 12,
   parameter int unsigned SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [OP_W-1:0]   in_op,
   input  logic [FRAC:0]     in_t,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [OP_W-1:0]   out_op,
   output logic [FRAC:0]     out_t,
   output logic [SIDE_W-1:0] out_side
);
   localparam int unsigned T_W   = FRAC + 1;
   localparam int unsigned SH    = OP_W + 8;
   localparam logic [63:0] ONE_SH = 64'd1 << SH;
   // Truncated reciprocal: the estimate is the true quotient or one less.
   localparam logic [SH:0]     RECIP = (SH + 1)'(ONE_SH / 64'(DIV));
   localparam logic [OP_W-1:0] DIV_C = OP_W'(DIV);
   localparam logic [T_W-1:0]  ONE_T = T_W'(1) << FRAC;

   logic [OP_W+T_W-1:0]  prod1;
   logic [OP_W+SH:0]     prod2;
   logic [OP_W-1:0]      back;
   logic [OP_W-1:0]      rem;
   logic [OP_W-1:0]      quo;

   logic                 v1_ff, v2_ff, v3_ff;
   logic [OP_W-1:0]      op1_ff, op2_ff, op3_ff;
   logic [SIDE_W-1:0]    side1_ff, side2_ff, side3_ff;
   logic [OP_W-1:0]      w1_ff, w2_ff;
   logic [OP_W-1:0]      qe2_ff;
   logic [T_W-1:0]       t3_ff;

   assign prod1 = in_op * in_t;
   assign prod2 = w1_ff * RECIP;
   assign back  = qe2_ff * DIV_C;
   assign rem   = w2_ff - back;
   assign quo   = (rem >= DIV_C) ? qe2_ff + OP_W'(1) : qe2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op1_ff   <= in_op;
         side1_ff <= in_side;
         w1_ff    <= prod1[FRAC +: OP_W];
         op2_ff   <= op1_ff;
         side2_ff <= side1_ff;
         w2_ff    <= w1_ff;
         qe2_ff   <= prod2[SH +: OP_W];
         op3_ff   <= op2_ff;
         side3_ff <= side2_ff;
         t3_ff    <= ONE_T - T_W'(quo);
      end
   end

   assign out_valid = v3_ff;
   assign out_op    = op3_ff;
   assign out_t     = t3_ff;
   assign out_side  = side3_ff;
endmodule

// ===== rtl/gmf_out_buffer.sv =====
`timescale 1ns / 1ps
module gmf_out_buffer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  gmf_pkg::result_type    push_data,
   output logic                   advance,
   gmf_rsp_if.source              rsp_ch
);
   import gmf_pkg::*;

   result_type  slot_ff [2];
   logic        wr_ff, rd_ff;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;
   logic        pop;
   result_type  head;

   assign pop      = rsp_ch.valid && rsp_ch.ready;
   assign advance  = (count_ff != 2'd2) || rsp_ch.ready;
   assign count_in = count_ff + 2'(push) - 2'(pop);
   assign head     = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   assign rsp_ch.valid       = count_ff != 2'd0;
   assign rsp_ch.field_y     = head.field_y;
   assign rsp_ch.saturated   = head.saturated;
   assign rsp_ch.last_result = head.last_result;
endmodule
